/* hw/rtl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge of i_clk, off while reset is low.
`define FCB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Condition that must never be true.
`define FCB_ASSERT_NEVER(lbl, expr, msg) \
    `FCB_ASSERT(lbl, !(expr), msg)

`endif

/* hw/rtl/fcb_pkg.sv */
`default_nettype none

package fcb_pkg;

    typedef struct packed {
        logic       kind;
        logic [1:0] plane;
        logic [7:0] sample_a;
        logic [7:0] sample_b;
        logic [7:0] sample_c;
        logic [7:0] sample_d;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_a;
        logic [7:0] out_b;
        logic [7:0] out_c;
        logic [7:0] out_d;
        logic [7:0] fade_weight;
    } t_out_word;

    typedef struct packed {
        logic [7:0]  opacity;
        logic        fade_out_mode;
        logic [11:0] fade_frames;
    } t_fade_cfg;

    typedef struct packed {
        logic busy;
        logic deliver;
    } t_fade_ctl;

    localparam logic [2:0] REG_OPACITY    = 3'd0;
    localparam logic [2:0] REG_COLOR_Y    = 3'd1;
    localparam logic [2:0] REG_COLOR_CB   = 3'd2;
    localparam logic [2:0] REG_COLOR_CR   = 3'd3;
    localparam logic [2:0] REG_FADE_MODE  = 3'd4;
    localparam logic [2:0] REG_FADE_FRAMES = 3'd5;

    localparam logic       KIND_TICK  = 1'b0;
    localparam logic [1:0] PLANE_LUMA = 2'd0;
    localparam logic [1:0] PLANE_CB   = 2'd1;

    localparam logic [11:0] MAX_FRAMES = 12'd3000;

    // Color weight from the Q8 level: round, then clamp to 255.
    function automatic logic [7:0] weight_of(input logic [15:0] level);
        logic [16:0] sum;
        sum = {1'b0, level} + 17'd128;
        return (sum[16:8] > 9'd255) ? 8'hFF : sum[15:8];
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/fade_to_color_blend.sv */
// Channel   Direction  Handshake                 Word
// input     in         i_in_valid / o_in_stall   fcb_pkg::t_in_word
// output    out        o_out_valid / i_out_stall fcb_pkg::t_out_word
// config    in/out     psel penable pwrite       paddr pwdata prdata
//
// Sample group: one word per cycle while o_in_stall is low; the result
// passes the lane product register, then the output register.
// Frame tick: the input stalls after accept until the tick result goes
// out; the fade step is formed by the 16-step serial divider.
// Synchronous active-low reset: fade level to zero, no tick seen yet.
// An output stall holds the output word and backs up through the lane stage.
`default_nettype none

`include "assert_macros.svh"

module fade_to_color_blend #(
    parameter int LANES = 4
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire fcb_pkg::t_in_word  i_in_word,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output fcb_pkg::t_out_word      o_out_word,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic         [4:0] paddr,
    input  wire logic        [31:0] pwdata,
    output logic             [31:0] prdata,
    output logic                    pready
);

    localparam int FIELD_COUNT = 4;
    localparam int NUM_LANES   = (LANES < FIELD_COUNT) ? LANES : FIELD_COUNT;

    logic [7:0]  r_opacity;
    logic [7:0]  r_color_y;
    logic [7:0]  r_color_cb;
    logic [7:0]  r_color_cr;
    logic        r_fade_mode;
    logic [11:0] r_fade_frames;

    logic        cfg_wr;
    fcb_pkg::t_fade_cfg fade_cfg;
    fcb_pkg::t_fade_ctl fade_ctl;
    logic [15:0] fade_level;

    logic        in_acc;
    logic        tick_acc;
    logic        grp_acc;
    logic [7:0]  op1;
    logic [7:0]  color;
    logic        out_free;
    logic        a_move;
    logic        deliver_ok;

    logic        r_a_valid;
    logic [7:0]  r_a_weight;
    logic        r_out_valid;
    fcb_pkg::t_out_word r_out_word;

    logic [FIELD_COUNT-1:0][7:0] samples;
    logic [FIELD_COUNT-1:0][7:0] lane_res;

    // ---- configuration
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_opacity     <= 8'd150;
            r_color_y     <= 8'd0;
            r_color_cb    <= 8'd128;
            r_color_cr    <= 8'd128;
            r_fade_mode   <= 1'b0;
            r_fade_frames <= 12'd75;
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                fcb_pkg::REG_OPACITY:     r_opacity     <= pwdata[7:0];
                fcb_pkg::REG_COLOR_Y:     r_color_y     <= pwdata[7:0];
                fcb_pkg::REG_COLOR_CB:    r_color_cb    <= pwdata[7:0];
                fcb_pkg::REG_COLOR_CR:    r_color_cr    <= pwdata[7:0];
                fcb_pkg::REG_FADE_MODE:   r_fade_mode   <= pwdata[0];
                fcb_pkg::REG_FADE_FRAMES: r_fade_frames <= pwdata[11:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            fcb_pkg::REG_OPACITY:     prdata = {24'd0, r_opacity};
            fcb_pkg::REG_COLOR_Y:     prdata = {24'd0, r_color_y};
            fcb_pkg::REG_COLOR_CB:    prdata = {24'd0, r_color_cb};
            fcb_pkg::REG_COLOR_CR:    prdata = {24'd0, r_color_cr};
            fcb_pkg::REG_FADE_MODE:   prdata = {31'd0, r_fade_mode};
            fcb_pkg::REG_FADE_FRAMES: prdata = {20'd0, r_fade_frames};
            default:                  prdata = 32'd0;
        endcase
    end

    assign fade_cfg.opacity       = r_opacity;
    assign fade_cfg.fade_out_mode = r_fade_mode;
    assign fade_cfg.fade_frames   = r_fade_frames;

    // ---- handshake
    assign out_free   = !r_out_valid || !i_out_stall;
    assign a_move     = r_a_valid && out_free;
    // a tick result goes out only after any older group has left
    assign deliver_ok = !r_a_valid && out_free;
    assign o_in_stall = fade_ctl.busy || (r_a_valid && !out_free);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign tick_acc   = in_acc && (i_in_word.kind == fcb_pkg::KIND_TICK);
    assign grp_acc    = in_acc && (i_in_word.kind != fcb_pkg::KIND_TICK);

    fcb_fade u_fade (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (fade_cfg),
        .i_start      (tick_acc),
        .i_deliver_ok (deliver_ok),
        .o_ctl        (fade_ctl),
        .o_level      (fade_level)
    );

    // ---- lanes
    assign op1 = fcb_pkg::weight_of(fade_level);

    always_comb begin
        case (i_in_word.plane)
            fcb_pkg::PLANE_LUMA: color = r_color_y;
            fcb_pkg::PLANE_CB:   color = r_color_cb;
            default:             color = r_color_cr;
        endcase
    end

    assign samples[0] = i_in_word.sample_a;
    assign samples[1] = i_in_word.sample_b;
    assign samples[2] = i_in_word.sample_c;
    assign samples[3] = i_in_word.sample_d;

    for (genvar g = 0; g < FIELD_COUNT; g++) begin : g_lane
        if (g < NUM_LANES) begin : g_on
            fcb_lane u_lane (
                .i_clk    (i_clk),
                .i_load   (grp_acc),
                .i_op1    (op1),
                .i_color  (color),
                .i_sample (samples[g]),
                .o_result (lane_res[g])
            );
        end else begin : g_off
            assign lane_res[g] = 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (grp_acc) begin
            r_a_valid <= 1'b1;
        end else if (a_move) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (grp_acc) begin
            r_a_weight <= op1;
        end
    end

    // ---- merge into the output word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (a_move) begin
            r_out_valid            <= 1'b1;
            r_out_word.out_a       <= lane_res[0];
            r_out_word.out_b       <= lane_res[1];
            r_out_word.out_c       <= lane_res[2];
            r_out_word.out_d       <= lane_res[3];
            r_out_word.fade_weight <= r_a_weight;
        end else if (fade_ctl.deliver) begin
            r_out_valid            <= 1'b1;
            r_out_word.out_a       <= 8'd0;
            r_out_word.out_b       <= 8'd0;
            r_out_word.out_c       <= 8'd0;
            r_out_word.out_d       <= 8'd0;
            r_out_word.fade_weight <= op1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // ---- checks
    `FCB_ASSERT(a_tick_starts_fade, tick_acc |=> fade_ctl.busy, "tick did not start fade")
    `FCB_ASSERT_NEVER(a_tick_order, fade_ctl.deliver && r_a_valid, "tick passed a group")
    `FCB_ASSERT(a_group_staged, grp_acc |=> r_a_valid, "group word lost in lane stage")

endmodule

`default_nettype wire

/* hw/rtl/fcb_lane.sv */
`default_nettype none

module fcb_lane (
    input  wire logic       i_clk,
    input  wire logic       i_load,
    input  wire logic [7:0] i_op1,
    input  wire logic [7:0] i_color,
    input  wire logic [7:0] i_sample,
    output logic      [7:0] o_result
);

    logic [7:0]  op0;
    logic [15:0] prod_s;
    logic [15:0] prod_c;
    logic [16:0] sum;
    logic [15:0] r_sum;
    logic [16:0] quo_t;

    assign op0    = 8'd255 - i_op1;
    assign prod_s = {8'd0, op0} * {8'd0, i_sample};
    assign prod_c = {8'd0, i_op1} * {8'd0, i_color};
    // op0 + op1 = 255, so the sum stays below 2^16
    assign sum    = {1'b0, prod_s} + {1'b0, prod_c} + 17'd127;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_sum <= sum[15:0];
        end
    end

    // x / 255 for x below 65535: (x + (x >> 8) + 1) >> 8
    assign quo_t    = {1'b0, r_sum} + {9'b0, r_sum[15:8]} + 17'd1;
    assign o_result = quo_t[15:8];

endmodule

`default_nettype wire

/* hw/rtl/fcb_div.sv */
`default_nettype none

module fcb_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [15:0] i_dividend,
    input  wire logic [11:0] i_divisor,
    output logic      [15:0] o_quotient,
    output logic             o_done
);

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    t_state      r_state;
    logic [3:0]  r_cnt;
    logic [11:0] r_rem;
    logic [15:0] r_quo;
    logic [11:0] r_div;
    logic        r_done;

    logic [12:0] rem_sh;
    logic [12:0] diff;
    logic        fits;
    logic [11:0] n_rem;

    // one quotient bit per cycle, restoring
    assign rem_sh = {r_rem, r_quo[15]};
    assign diff   = rem_sh - {1'b0, r_div};
    assign fits   = rem_sh >= {1'b0, r_div};
    assign n_rem  = fits ? diff[11:0] : rem_sh[11:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= 4'd0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_quo   <= i_dividend;
                        r_rem   <= 12'd0;
                        r_div   <= i_divisor;
                        r_cnt   <= 4'd15;
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    r_quo <= {r_quo[14:0], fits};
                    r_rem <= n_rem;
                    if (r_cnt == 4'd0) begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_cnt <= r_cnt - 4'd1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;

endmodule

`default_nettype wire

/* hw/rtl/fcb_fade.sv */
`default_nettype none

module fcb_fade (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire fcb_pkg::t_fade_cfg i_cfg,
    input  wire logic              i_start,
    input  wire logic              i_deliver_ok,
    output fcb_pkg::t_fade_ctl     o_ctl,
    output logic            [15:0] o_level
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIVIDE,
        S_UPDATE,
        S_DELIVER
    } t_state;

    t_state      r_state;
    logic [15:0] r_level;
    logic [1:0]  r_prior;

    logic [7:0]  op;
    logic [11:0] frames;
    logic [15:0] target;
    logic [15:0] quotient;
    logic        div_done;
    logic [15:0] step;
    logic        reload;
    logic [15:0] base;
    logic [16:0] up_sum;
    logic [15:0] in_level;
    logic [15:0] out_level;
    logic [15:0] n_level;

    always_comb begin
        op = (i_cfg.opacity == 8'd0) ? 8'd1 : i_cfg.opacity;
        if (i_cfg.fade_frames == 12'd0) begin
            frames = 12'd1;
        end else if (i_cfg.fade_frames > fcb_pkg::MAX_FRAMES) begin
            frames = fcb_pkg::MAX_FRAMES;
        end else begin
            frames = i_cfg.fade_frames;
        end
        target = {op, 8'h00};
    end

    fcb_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .i_dividend (target),
        .i_divisor  (frames),
        .o_quotient (quotient),
        .o_done     (div_done)
    );

    always_comb begin
        step      = (quotient == 16'd0) ? 16'd1 : quotient;
        reload    = {1'b0, i_cfg.fade_out_mode} != r_prior;
        if (reload) begin
            base = i_cfg.fade_out_mode ? target : 16'd0;
        end else begin
            base = r_level;
        end
        up_sum    = {1'b0, base} + {1'b0, step};
        in_level  = (up_sum > {1'b0, target}) ? target : up_sum[15:0];
        out_level = (base > step) ? base - step : 16'd0;
        n_level   = i_cfg.fade_out_mode ? out_level : in_level;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_level <= 16'd0;
            r_prior <= 2'd3;  // no tick seen yet
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_state <= S_DIVIDE;
                    end
                end
                S_DIVIDE: begin
                    if (div_done) begin
                        r_state <= S_UPDATE;
                    end
                end
                S_UPDATE: begin
                    r_level <= n_level;
                    r_prior <= {1'b0, i_cfg.fade_out_mode};
                    r_state <= S_DELIVER;
                end
                S_DELIVER: begin
                    if (i_deliver_ok) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ctl.busy    = r_state != S_IDLE;
    assign o_ctl.deliver = (r_state == S_DELIVER) && i_deliver_ok;
    assign o_level       = r_level;

endmodule

`default_nettype wire

/* tb/tb_fade_to_color_blend.sv */
`timescale 1ns / 100ps

class blend_tracker;
    localparam int REPORT_LIMIT = 10;

    logic [7:0]  opacity;
    logic [7:0]  luma;
    logic [7:0]  blue_diff;
    logic [7:0]  red_diff;
    logic        mode;
    logic [11:0] frames;

    logic [15:0] level;
    logic [1:0]  tick_mode;

    fcb_pkg::t_out_word expected_words[$];
    int failures;

    function new();
        opacity   = 8'd150;
        luma      = 8'd0;
        blue_diff = 8'd128;
        red_diff  = 8'd128;
        mode      = 1'b0;
        frames    = 12'd75;
        level     = 16'd0;
        tick_mode = 2'd3;   // no tick seen yet
        failures  = 0;
    endfunction

    function void set_reg(input logic [2:0] idx, input int unsigned val);
        case (idx)
            fcb_pkg::REG_OPACITY:     opacity   = val[7:0];
            fcb_pkg::REG_COLOR_Y:     luma      = val[7:0];
            fcb_pkg::REG_COLOR_CB:    blue_diff = val[7:0];
            fcb_pkg::REG_COLOR_CR:    red_diff  = val[7:0];
            fcb_pkg::REG_FADE_MODE:   mode      = val[0];
            fcb_pkg::REG_FADE_FRAMES: frames    = val[11:0];
            default: ;
        endcase
    endfunction

    function void step_fade();
        int unsigned op;
        int unsigned fr;
        int unsigned target;
        int unsigned stp;
        int unsigned lv;
        op = (opacity == 8'd0) ? 1 : opacity;
        fr = (frames == 12'd0) ? 1 : frames;
        if (fr > fcb_pkg::MAX_FRAMES)
            fr = fcb_pkg::MAX_FRAMES;
        target = op << 8;
        stp = target / fr;
        if (stp < 1)
            stp = 1;
        if ({1'b0, mode} != tick_mode) begin
            level = mode ? target[15:0] : 16'd0;
            tick_mode = {1'b0, mode};
        end
        lv = level;
        if (!mode) begin
            lv = lv + stp;
            if (lv > target)
                lv = target;
        end else begin
            lv = (lv > stp) ? lv - stp : 0;
        end
        level = lv[15:0];
    endfunction

    function logic [7:0] weight();
        int unsigned w;
        w = (int'(level) + 128) >> 8;
        return (w > 255) ? 8'hFF : w[7:0];
    endfunction

    function logic [7:0] blend_lane(input logic [7:0] s, input logic [7:0] c,
                                    input logic [7:0] op1);
        int unsigned r;
        r = ((255 - op1) * s + op1 * c + 127) / 255;
        return r[7:0];
    endfunction

    function void accept_input(input fcb_pkg::t_in_word w);
        fcb_pkg::t_out_word exp;
        logic [7:0] op1;
        logic [7:0] c;
        exp = '0;
        if (w.kind == fcb_pkg::KIND_TICK) begin
            step_fade();
            exp.fade_weight = weight();
        end else begin
            op1 = weight();
            if (w.plane == fcb_pkg::PLANE_LUMA)
                c = luma;
            else if (w.plane == fcb_pkg::PLANE_CB)
                c = blue_diff;
            else
                c = red_diff;  // plane code three falls back to Cr
            exp.out_a = blend_lane(w.sample_a, c, op1);
            exp.out_b = blend_lane(w.sample_b, c, op1);
            exp.out_c = blend_lane(w.sample_c, c, op1);
            exp.out_d = blend_lane(w.sample_d, c, op1);
            exp.fade_weight = op1;
        end
        expected_words.push_back(exp);
    endfunction

    function void check_output(input fcb_pkg::t_out_word got);
        fcb_pkg::t_out_word exp;
        if (expected_words.size() == 0) begin
            failures++;
            if (failures <= REPORT_LIMIT)
                $display("unexpected output word: a=%0d b=%0d c=%0d d=%0d w=%0d",
                         got.out_a, got.out_b, got.out_c, got.out_d, got.fade_weight);
            return;
        end
        exp = expected_words.pop_front();
        if (got.out_a !== exp.out_a || got.out_b !== exp.out_b ||
            got.out_c !== exp.out_c || got.out_d !== exp.out_d ||
            got.fade_weight !== exp.fade_weight) begin
            failures++;
            if (failures <= REPORT_LIMIT)
                $display("mismatch: exp a=%0d b=%0d c=%0d d=%0d w=%0d,",
                         exp.out_a, exp.out_b, exp.out_c, exp.out_d, exp.fade_weight,
                         " got a=%0d b=%0d c=%0d d=%0d w=%0d",
                         got.out_a, got.out_b, got.out_c, got.out_d, got.fade_weight);
        end
    endfunction

    function int pending();
        return expected_words.size();
    endfunction
endclass

module tb_fade_to_color_blend;

    localparam logic       KIND_GROUP  = 1'b1;
    localparam logic [1:0] PLANE_CR    = 2'd2;
    localparam logic [1:0] PLANE_SPARE = 2'd3;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    fcb_pkg::t_in_word  in_word = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    fcb_pkg::t_out_word out_word;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [4:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    blend_tracker tracker = new();

    // shared between the sender and the receiver process
    bit calm = 1'b0;
    bit hold_req = 1'b0;

    fade_to_color_blend dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    function automatic logic [7:0] rand_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 8'h00;
        else if (r < 20)
            return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic fcb_pkg::t_in_word group_word(input logic [1:0] plane,
                                                     input logic [7:0] a,
                                                     input logic [7:0] b,
                                                     input logic [7:0] c,
                                                     input logic [7:0] d);
        fcb_pkg::t_in_word w;
        w.kind = KIND_GROUP;
        w.plane = plane;
        w.sample_a = a;
        w.sample_b = b;
        w.sample_c = c;
        w.sample_d = d;
        return w;
    endfunction

    function automatic fcb_pkg::t_in_word tick_word();
        fcb_pkg::t_in_word w;
        w = '0;
        w.kind = fcb_pkg::KIND_TICK;
        w.plane = 2'($urandom_range(0, 3));   // ignored on a tick, randomized anyway
        w.sample_a = 8'($urandom_range(0, 255));
        return w;
    endfunction

    function automatic fcb_pkg::t_in_word random_word(input int tick_pct);
        if ($urandom_range(0, 99) < tick_pct)
            return tick_word();
        return group_word(2'($urandom_range(0, 3)), rand_sample(), rand_sample(),
                          rand_sample(), rand_sample());
    endfunction

    // Offer a word and return at the edge where it is taken.
    task automatic send_word(input fcb_pkg::t_in_word w);
        in_valid <= 1'b1;
        in_word <= w;
        do @(posedge i_clk); while (in_stall);
        tracker.accept_input(w);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input int unsigned val);
        drain();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        tracker.set_reg(idx, val);
        @(posedge i_clk);
    endtask

    task automatic set_fade(input int unsigned op, input int unsigned fr, input bit out_mode);
        cfg_write(fcb_pkg::REG_OPACITY, op);
        cfg_write(fcb_pkg::REG_FADE_FRAMES, fr);
        cfg_write(fcb_pkg::REG_FADE_MODE, {31'd0, out_mode});
    endtask

    task automatic set_color(input int unsigned y, input int unsigned cb, input int unsigned cr);
        cfg_write(fcb_pkg::REG_COLOR_Y, y);
        cfg_write(fcb_pkg::REG_COLOR_CB, cb);
        cfg_write(fcb_pkg::REG_COLOR_CR, cr);
    endtask

    task automatic run_words(input int count, input int tick_pct);
        int gap;
        for (int i = 0; i < count; i++) begin
            send_word(random_word(tick_pct));
            gap = (calm || $urandom_range(0, 2) != 0) ? 0 : gap_len();
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // receiver: checks words and drives the output stall
    initial begin
        int hold_left;
        int burst_left;
        hold_left = 0;
        burst_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && out_valid === 1'b1 && !out_stall)
                tracker.check_output(out_word);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (calm) begin
                burst_left = 0;
                out_stall <= 1'b0;
            end else if (burst_left > 0) begin
                burst_left--;
                out_stall <= 1'b1;
            end else begin
                burst_left = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
                out_stall <= (burst_left > 0);
                if (burst_left > 0)
                    burst_left--;
            end
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // before any tick the weight is zero: samples pass through
        send_word(group_word(fcb_pkg::PLANE_LUMA, 8'h00, 8'hFF, 8'h55, 8'hAA));
        send_word(group_word(PLANE_SPARE, 8'hFF, 8'h00, 8'hAA, 8'h55));

        set_color(255, 0, 77);
        set_fade(255, 1, 1'b0);
        send_word(tick_word());
        send_word(group_word(fcb_pkg::PLANE_LUMA, 8'h00, 8'hFF, 8'h80, 8'h01));
        send_word(group_word(fcb_pkg::PLANE_CB, 8'hFF, 8'h00, 8'h7F, 8'hFE));
        send_word(group_word(PLANE_CR, 8'h55, 8'hAA, 8'h00, 8'hFF));
        send_word(group_word(PLANE_SPARE, 8'hAA, 8'h55, 8'hFF, 8'h00));

        // mode change reloads the level
        cfg_write(fcb_pkg::REG_FADE_MODE, 1);
        send_word(tick_word());
        send_word(group_word(PLANE_CR, 8'hFF, 8'hFF, 8'h00, 8'h00));

        // opacity and frame count zero both act as one
        set_fade(0, 0, 1'b0);
        send_word(tick_word());
        send_word(group_word(fcb_pkg::PLANE_LUMA, 8'hFF, 8'h00, 8'h10, 8'hEF));

        // frame count above the cap
        set_fade(200, 4095, 1'b0);
        send_word(tick_word());
        send_word(tick_word());
        send_word(group_word(fcb_pkg::PLANE_CB, 8'h00, 8'hFF, 8'h33, 8'hCC));

        // opacity lowered mid fade-in: level clamps to the new target
        set_fade(255, 2, 1'b0);
        send_word(tick_word());
        cfg_write(fcb_pkg::REG_OPACITY, 50);
        send_word(tick_word());
        send_word(group_word(fcb_pkg::PLANE_LUMA, 8'h00, 8'hFF, 8'h80, 8'h40));

        // opacity lowered mid fade-out: keeps stepping down
        set_fade(255, 4, 1'b1);
        send_word(tick_word());
        cfg_write(fcb_pkg::REG_OPACITY, 10);
        send_word(tick_word());
        send_word(tick_word());
        send_word(group_word(PLANE_CR, 8'h00, 8'hFF, 8'h80, 8'h40));

        set_color($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
        set_fade($urandom_range(1, 255), $urandom_range(1, 8), 1'b0);
        run_words(100, 12);

        set_fade($urandom_range(1, 255), $urandom_range(1, 8), 1'b1);
        run_words(100, 12);

        set_color(0, 255, 0);
        set_fade(255, 3000, 1'b0);
        hold_req = 1'b1;   // receiver backs off, sender keeps offering
        run_words(100, 12);

        set_color(255, 0, 255);
        set_fade(1, 4095, 1'b1);
        run_words(100, 12);

        set_fade(0, 0, 1'b0);
        run_words(100, 12);

        set_color($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
        set_fade($urandom_range(1, 255), $urandom_range(1, 20), $urandom_range(0, 1) != 0);
        calm = 1'b1;
        run_words(100, 12);
        drain();
        calm = 1'b0;

        set_color($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
        set_fade($urandom_range(0, 255), $urandom_range(0, 4095), $urandom_range(0, 1) != 0);
        run_words(100, 12);

        // new opacity without a mode change, mid fade
        cfg_write(fcb_pkg::REG_OPACITY, $urandom_range(1, 255));
        cfg_write(fcb_pkg::REG_FADE_FRAMES, $urandom_range(1, 12));
        run_words(100, 20);

        drain();
        repeat (40) @(posedge i_clk);
        if (tracker.failures == 0 && tracker.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
